FILE: rtl/u8san_pkg.sv
// Shared types, constants and sequence-judging functions of the UTF-8 stream sanitizer.
package u8san_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned HoldN  = 4;
  localparam int unsigned CountW = 3;
  localparam int unsigned RemW   = 2;

  localparam logic [ByteW-1:0] SubstReset = 8'h20;

  localparam logic [ByteW-1:0] MaskTop2  = 8'hC0;
  localparam logic [ByteW-1:0] MaskTop3  = 8'hE0;
  localparam logic [ByteW-1:0] MaskTop4  = 8'hF0;
  localparam logic [ByteW-1:0] MaskTop5  = 8'hF8;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Tag  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Tag  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Tag  = 8'hF0;
  localparam logic [ByteW-1:0] Lead2Min  = 8'hC2;
  localparam logic [ByteW-1:0] LeadE0    = 8'hE0;
  localparam logic [ByteW-1:0] LeadED    = 8'hED;
  localparam logic [ByteW-1:0] LeadF0    = 8'hF0;
  localparam logic [ByteW-1:0] LeadF4    = 8'hF4;
  localparam logic [ByteW-1:0] ContA0    = 8'hA0;
  localparam logic [ByteW-1:0] Cont90    = 8'h90;
  localparam logic [ByteW-1:0] Cont8F    = 8'h8F;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef enum logic [2:0] {
    K_END,
    K_STOP,
    K_PASS,
    K_GOOD,
    K_BAD
  } kind_e;

  typedef struct packed {
    logic load;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  last;
    logic  out_free;
  } dp_status_t;

  function automatic logic [CountW-1:0] seq_len(input logic [ByteW-1:0] lead);
    logic [CountW-1:0] len;
    len = 3'd0;
    if (lead[ByteW-1] == 1'b0) begin
      len = 3'd1;
    end else if ((lead & MaskTop3) == Lead2Tag) begin
      len = 3'd2;
    end else if ((lead & MaskTop4) == Lead3Tag) begin
      len = 3'd3;
    end else if ((lead & MaskTop5) == Lead4Tag) begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic is_cont(input logic [ByteW-1:0] b);
    return (b & MaskTop2) == ContTag;
  endfunction

  function automatic logic well_formed(input logic [ByteW-1:0] b0, input logic [ByteW-1:0] b1,
                                       input logic [ByteW-1:0] b2, input logic [ByteW-1:0] b3,
                                       input logic [CountW-1:0] len);
    logic ok;
    ok = 1'b1;
    unique case (len)
      3'd1: ok = 1'b1;
      3'd2: ok = (b0 >= Lead2Min) && is_cont(b1);
      3'd3: begin
        ok = is_cont(b1) && is_cont(b2);
        if (b0 == LeadE0 && b1 < ContA0) ok = 1'b0;
        if (b0 == LeadED && b1 >= ContA0) ok = 1'b0;
      end
      3'd4: begin
        ok = is_cont(b1) && is_cont(b2) && is_cont(b3);
        if (b0 == LeadF0 && b1 < Cont90) ok = 1'b0;
        if (b0 == LeadF4 && b1 > Cont8F) ok = 1'b0;
        if (b0 > LeadF4) ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic kind_e classify(input logic [ByteW-1:0] b0, input logic [ByteW-1:0] b1,
                                     input logic [ByteW-1:0] b2, input logic [ByteW-1:0] b3,
                                     input logic [CountW-1:0] n, input logic eos);
    logic [CountW-1:0] len;
    kind_e             k;
    len = seq_len(b0);
    if (n == 3'd0) begin
      k = K_END;
    end else if (len != 3'd0 && n < len && !eos) begin
      k = K_STOP;
    end else if (len != 3'd0 && n >= len && well_formed(b0, b1, b2, b3, len)) begin
      k = K_GOOD;
    end else begin
      k = K_BAD;
    end
    return k;
  endfunction

endpackage

FILE: rtl/u8san_ctrl.sv
// Controller state machine of the UTF-8 stream sanitizer: sequences loading and emission.
module u8san_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  u8san_pkg::dp_status_t  status_i,
  output u8san_pkg::ctrl_cmd_t   cmd_o,
  output logic                   in_stall_o,
  output u8san_pkg::state_e      state_o
);
  import u8san_pkg::*;

  state_e state_q, state_d;
  logic   emissive;
  logic   finish;
  logic   ready;

  always_comb begin
    emissive   = (status_i.kind == K_PASS) || (status_i.kind == K_GOOD) ||
                 (status_i.kind == K_BAD);
    cmd_o.emit = (state_q == ST_SCAN) && emissive && status_i.out_free;
    finish     = (state_q == ST_SCAN) &&
                 ((status_i.kind == K_END) || (status_i.kind == K_STOP) ||
                  (cmd_o.emit && status_i.last));
    ready      = (state_q == ST_IDLE) || finish;
    cmd_o.load = in_valid_i && ready;
    in_stall_o = !ready;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cmd_o.load) begin
          state_d = ST_SCAN;
        end else if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

FILE: rtl/u8san_dp.sv
// Datapath of the UTF-8 stream sanitizer: held bytes, judging logic and output register.
module u8san_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  u8san_pkg::ctrl_cmd_t          cmd_i,
  output u8san_pkg::dp_status_t         status_o,
  input  logic [u8san_pkg::ByteW-1:0]   data_byte_i,
  input  logic                          end_of_stream_i,
  input  logic                          cfg_we_i,
  input  logic [u8san_pkg::ByteW-1:0]   cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [u8san_pkg::ByteW-1:0]   out_byte_o,
  output logic                          substituted_o,
  output logic                          run_last_o,
  output logic                          stream_last_o
);
  import u8san_pkg::*;

  logic [ByteW-1:0]  hold_q [HoldN];
  logic [ByteW-1:0]  hold_d [HoldN];
  logic [CountW-1:0] count_q, count_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic              eos_q, eos_d;
  logic [ByteW-1:0]  subst_q;
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q;
  logic              out_sub_q;
  logic              out_run_last_q;
  logic              out_stream_last_q;

  logic [CountW-1:0] cur_len;
  logic [CountW-1:0] len_less;
  logic [CountW-1:0] base;
  kind_e             cur_kind;
  kind_e             nxt_kind;
  logic              nxt_done;
  logic              last;

  always_comb begin
    cur_len  = seq_len(hold_q[0]);
    len_less = cur_len - 3'd1;
    cur_kind = (rem_q != '0) ? K_PASS :
               classify(hold_q[0], hold_q[1], hold_q[2], hold_q[3], count_q, eos_q);
    nxt_kind = classify(hold_q[1], hold_q[2], hold_q[3], '0, count_q - 3'd1, eos_q);
    nxt_done = (nxt_kind == K_END) || (nxt_kind == K_STOP);
    last     = nxt_done && ((cur_kind == K_BAD) ||
                            (cur_kind == K_GOOD && cur_len == 3'd1) ||
                            (cur_kind == K_PASS && rem_q == 2'd1));
    status_o.kind     = cur_kind;
    status_o.last     = last;
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    hold_d  = hold_q;
    count_d = count_q;
    rem_d   = rem_q;
    base    = count_q;
    if (cmd_i.emit) begin
      for (int i = 0; i < HoldN - 1; i++) begin
        hold_d[i] = hold_q[i+1];
      end
      count_d = count_q - 3'd1;
      base    = count_q - 3'd1;
      priority case (cur_kind)
        K_GOOD:  rem_d = len_less[RemW-1:0];
        K_PASS:  rem_d = rem_q - 2'd1;
        default: rem_d = '0;
      endcase
    end
    if (cmd_i.load) begin
      hold_d[base[1:0]] = data_byte_i;
      count_d           = base + 3'd1;
    end
    eos_d = cmd_i.load ? end_of_stream_i : eos_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rem_q       <= '0;
      eos_q       <= 1'b0;
      subst_q     <= SubstReset;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rem_q       <= rem_d;
      eos_q       <= eos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) subst_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    if (cmd_i.emit) begin
      out_byte_q        <= (cur_kind == K_BAD) ? subst_q : hold_q[0];
      out_sub_q         <= (cur_kind == K_BAD);
      out_run_last_q    <= last;
      out_stream_last_q <= last && eos_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign substituted_o = out_sub_q;
  assign run_last_o    = out_run_last_q;
  assign stream_last_o = out_stream_last_q;

endmodule

FILE: rtl/utf8_stream_sanitizer.sv
// Top level of the UTF-8 stream sanitizer: controller, datapath and checks.
// The block takes one byte per accepted item and gives one result per byte it consumes,
// one result per cycle through its output register while the output is not stalled. An
// ASCII byte, or a byte that is only held as part of an unfinished sequence, has at most
// one result, so ASCII text streams at one byte per cycle while the output is not stalled;
// the item that completes or breaks a held sequence gives its results one after another,
// up to four, and the next item is taken while its last result is emitted. The first
// result of an item is loaded into the output register after the item is taken into the
// held bytes, and a stalled output holds the input off. Rejected bytes come out as the
// substitute byte with the substituted flag set; the stream is valid UTF-8 exactly when no
// result of it is flagged. After reset the block is ready at once, with no clearing pass.
module utf8_stream_sanitizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [u8san_pkg::ByteW-1:0]   data_byte_i,
  input  logic                          end_of_stream_i,
  input  logic                          cfg_we_i,
  input  logic [u8san_pkg::ByteW-1:0]   cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [u8san_pkg::ByteW-1:0]   out_byte_o,
  output logic                          substituted_o,
  output logic                          run_last_o,
  output logic                          stream_last_o
);
  import u8san_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  state_e     state;

  u8san_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .state_o    (state)
  );

  u8san_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .substituted_o   (substituted_o),
    .run_last_o      (run_last_o),
    .stream_last_o   (stream_last_o)
  );

  a_stream_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_last_o |-> run_last_o)
    else $error("Stream end flagged on a result that does not end its item.");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state == ST_SCAN)
    else $error("Accepted item was not scanned.");

  a_pass_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.kind == K_PASS |-> state == ST_SCAN)
    else $error("Unfinished sequence left over while idle.");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the UTF-8 stream sanitizer: directed table, random text, checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit    = 1000;
  localparam int PressureAt   = 40;
  localparam int PressureHold = 90;
  localparam int SettleCycles = 8;
  localparam int PhaseItems   = 25;

  typedef struct packed {
    logic [u8san_pkg::ByteW-1:0] data;
    logic                        subst;
    logic                        run_last;
    logic                        stream_last;
  } result_t;

  typedef struct packed {
    logic [u8san_pkg::ByteW-1:0] data;
    logic                        eos;
  } stim_t;

  typedef struct packed {
    logic [u8san_pkg::ByteW-1:0] data;
    logic                        eos;
    logic                        typed;
    result_t                     want;
  } row_t;

  localparam result_t Untyped       = '0;
  localparam result_t RejectAtReset = '{u8san_pkg::SubstReset, 1'b1, 1'b1, 1'b0};

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [u8san_pkg::ByteW-1:0] data_byte_i;
  logic                        end_of_stream_i;
  logic                        cfg_we_i;
  logic [u8san_pkg::ByteW-1:0] cfg_wdata_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [u8san_pkg::ByteW-1:0] out_byte_o;
  logic                        substituted_o;
  logic                        run_last_o;
  logic                        stream_last_o;

  result_t      clean_bytes_q[$];
  logic [7:0]   pending_q[$];
  stim_t        text_q[$];
  logic [7:0]   substitute_code;
  int           mismatches;
  int           results_taken;
  bit           tx_burst;

  // Each row is one item; typed rows carry their single result, the rest use the predictor.
  row_t directed_rows [0:24] = '{
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{8'h7F, 1'b0, 1'b1, '{8'h7F, 1'b0, 1'b1, 1'b0}},
    '{8'h80, 1'b0, 1'b1, RejectAtReset},
    '{8'hFF, 1'b0, 1'b1, RejectAtReset},
    '{8'hF8, 1'b0, 1'b1, RejectAtReset},
    '{8'hC2, 1'b0, 1'b0, Untyped},
    '{8'h80, 1'b0, 1'b0, Untyped},
    '{8'hC1, 1'b0, 1'b0, Untyped},
    '{8'hBF, 1'b0, 1'b0, Untyped},
    '{8'hED, 1'b0, 1'b0, Untyped},
    '{8'hA0, 1'b0, 1'b0, Untyped},
    '{8'h80, 1'b0, 1'b0, Untyped},
    '{8'hF4, 1'b0, 1'b0, Untyped},
    '{8'h90, 1'b0, 1'b0, Untyped},
    '{8'h80, 1'b0, 1'b0, Untyped},
    '{8'h80, 1'b0, 1'b0, Untyped},
    '{8'hF0, 1'b0, 1'b0, Untyped},
    '{8'h90, 1'b0, 1'b0, Untyped},
    '{8'h80, 1'b0, 1'b0, Untyped},
    '{8'h80, 1'b0, 1'b0, Untyped},
    '{8'hC3, 1'b0, 1'b0, Untyped},
    '{8'h41, 1'b0, 1'b0, Untyped},
    '{8'hE2, 1'b0, 1'b0, Untyped},
    '{8'h82, 1'b1, 1'b0, Untyped},
    '{8'h41, 1'b1, 1'b1, '{8'h41, 1'b0, 1'b1, 1'b1}}
  };

  utf8_stream_sanitizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .substituted_o   (substituted_o),
    .run_last_o      (run_last_o),
    .stream_last_o   (stream_last_o)
  );

  function automatic int lead_length(input logic [7:0] b);
    if (!b[7]) return 1;
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  function automatic bit sequence_ok(input logic [7:0] w[$], input int p, input int len);
    bit ok;
    ok = 1'b1;
    for (int j = 1; j < len; j++) begin
      if (w[p + j][7:6] != 2'b10) ok = 1'b0;
    end
    if (len == 2 && w[p] < 8'hC2) ok = 1'b0;
    if (len == 3 && w[p] == 8'hE0 && w[p + 1] < 8'hA0) ok = 1'b0;
    if (len == 3 && w[p] == 8'hED && w[p + 1] >= 8'hA0) ok = 1'b0;
    if (len == 4 && w[p] == 8'hF0 && w[p + 1] < 8'h90) ok = 1'b0;
    if (len == 4 && w[p] == 8'hF4 && w[p + 1] > 8'h8F) ok = 1'b0;
    if (len == 4 && w[p] > 8'hF4) ok = 1'b0;
    return ok;
  endfunction

  function automatic void sanitize_byte(input logic [7:0] b, input logic eos,
                                        input logic typed, input result_t want);
    logic [7:0] win[$];
    result_t    outs[$];
    int         pos;
    int         len;
    win = pending_q;
    win.push_back(b);
    pos = 0;
    while (pos < win.size()) begin
      len = lead_length(win[pos]);
      if (len != 0 && win.size() - pos < len && !eos) break;
      if (len != 0 && win.size() - pos >= len && sequence_ok(win, pos, len)) begin
        for (int i = 0; i < len; i++) outs.push_back('{win[pos + i], 1'b0, 1'b0, 1'b0});
        pos += len;
      end else begin
        outs.push_back('{substitute_code, 1'b1, 1'b0, 1'b0});
        pos++;
      end
    end
    if (outs.size() > 0) begin
      outs[outs.size() - 1].run_last = 1'b1;
      outs[outs.size() - 1].stream_last = eos;
    end
    pending_q.delete();
    for (int i = pos; i < win.size(); i++) pending_q.push_back(win[i]);
    if (typed) outs = '{want};
    foreach (outs[i]) clean_bytes_q.push_back(outs[i]);
  endfunction

  function automatic void report_mismatch(input string what, input result_t want,
                                          input result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected byte %02h sub %0b run %0b stream %0b, got byte %02h sub %0b run %0b stream %0b",
               $realtime, what, want.data, want.subst, want.run_last, want.stream_last,
               seen.data, seen.subst, seen.run_last, seen.stream_last);
    end
  endfunction

  // Mostly well-formed characters with random content, some corrupted or cut short, some noise.
  function automatic void build_text(input int target);
    logic [7:0]  chars[$];
    logic [20:0] cp;
    int          kind;
    int          len;
    int          lo;
    int          hi;
    while (text_q.size() < target) begin
      chars.delete();
      kind = $urandom_range(0, 15);
      if (kind < 2) begin
        if ($urandom_range(0, 1) == 1) chars.push_back(8'($urandom_range(0, 255)));
        else chars.push_back(8'($urandom_range(8'hC0, 8'hFF)));
      end else begin
        len = $urandom_range(1, 4);
        case (len)
          1: begin lo = 'h0;     hi = 'h7F;     end
          2: begin lo = 'h80;    hi = 'h7FF;    end
          3: begin lo = 'h800;   hi = 'hFFFF;   end
          default: begin lo = 'h10000; hi = 'h10FFFF; end
        endcase
        cp = 21'($urandom_range(lo, hi));
        if ($urandom_range(0, 3) == 0) cp = ($urandom_range(0, 1) == 1) ? 21'(lo) : 21'(hi);
        if (len == 3 && cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h1000;
        case (len)
          1: chars.push_back(cp[7:0]);
          2: begin
            chars.push_back({3'b110, cp[10:6]});
            chars.push_back({2'b10, cp[5:0]});
          end
          3: begin
            chars.push_back({4'b1110, cp[15:12]});
            chars.push_back({2'b10, cp[11:6]});
            chars.push_back({2'b10, cp[5:0]});
          end
          default: begin
            chars.push_back({5'b11110, cp[20:18]});
            chars.push_back({2'b10, cp[17:12]});
            chars.push_back({2'b10, cp[11:6]});
            chars.push_back({2'b10, cp[5:0]});
          end
        endcase
        if (kind == 2) begin
          chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (kind == 3 && chars.size() > 1) begin
          repeat ($urandom_range(1, chars.size() - 1)) void'(chars.pop_back());
        end
      end
      foreach (chars[i]) text_q.push_back('{chars[i], 1'b0});
      if ($urandom_range(0, 9) == 0) text_q[text_q.size() - 1].eos = 1'b1;
    end
    text_q[text_q.size() - 1].eos = 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eos, input logic typed,
                           input result_t want);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_stream_i <= eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sanitize_byte(b, eos, typed, want);
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (clean_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_substitute(input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    substitute_code = v;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    logic [7:0] codes[4];
    stim_t      s;
    codes = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'h3F};
    mismatches      = 0;
    tx_burst        = 1'b0;
    substitute_code = u8san_pkg::SubstReset;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    data_byte_i     <= '0;
    end_of_stream_i <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].data, directed_rows[i].eos, directed_rows[i].typed,
                directed_rows[i].want);
    end
    drain_outputs();
    foreach (codes[p]) begin
      write_substitute(codes[p]);
      build_text(PhaseItems);
      while (text_q.size() != 0) begin
        s = text_q.pop_front();
        send_item(s.data, s.eos, 1'b0, Untyped);
      end
      drain_outputs();
    end
    if (mismatches == 0 && clean_bytes_q.size() == 0) begin
      $display("** utf8_stream_sanitizer: PASSED **");
    end else begin
      $display("** utf8_stream_sanitizer: FAILED **");
    end
    $finish;
  end

  // Receiver: random stall per item, with one long hold-off so the block backs up.
  initial begin
    int      hold;
    bit      rx_burst;
    result_t want;
    result_t seen;
    hold          = 0;
    rx_burst      = 1'b0;
    results_taken = 0;
    out_stall_i   <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        seen = '{out_byte_o, substituted_o, run_last_o, stream_last_o};
        if (clean_bytes_q.size() == 0) begin
          report_mismatch("unexpected result", Untyped, seen);
        end else begin
          want = clean_bytes_q.pop_front();
          if (want.data != seen.data || want.subst != seen.subst ||
              want.run_last != seen.run_last || want.stream_last != seen.stream_last) begin
            report_mismatch("result differs", want, seen);
          end
        end
        results_taken++;
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        if (results_taken == PressureAt) hold = PressureHold;
        else hold = rx_burst ? 0 : $urandom_range(0, 6);
      end else if (hold > 0) begin
        hold--;
      end
      out_stall_i <= (hold != 0);
    end
  end

  initial begin
    int idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) idle = 0;
      else idle++;
    end
    $display("** utf8_stream_sanitizer: FAILED **");
    $finish;
  end

endmodule
